### rtl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: command and
// status codes, datapath operations and the status returned to the controller.
// ----------------------------------------------------------------------------
package ple_pkg;

	// list size and field widths
	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int SLOT_W       = 8;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int LEN_W        = 5;

	// command codes of an input item
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_INSERT     = 3'd2,
		CMD_ERASE      = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_code_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_PAST_END = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_code_t;

	// operations issued by the controller to the datapath
	typedef enum logic [2:0] {
		DP_NOP,
		DP_EXEC,
		DP_DUMP_START,
		DP_DUMP_ELEM,
		DP_DUMP_EMPTY
	} dp_op_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic out_free;
		logic cnt_zero;
		logic dump_last;
	} dp_sts_t;

endpackage

### rtl/positional_list_engine_unit.sv
`timescale 1ns / 1ps
// A push, insert or erase result appears at the output in the cycle after the item is accepted.
// Throughput: one non-dump item per cycle while results are taken, set by the cell shift.
// A dump clears the dump counter when accepted, then loads one result per cycle from the front
// cell while results are taken, and takes the next item once its last result is loaded.
// Reset clears the element count, the controller and the output valid flag; cells are not reset.
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of signed values with push, insert, erase and dump
// commands; controller and datapath joined by operation and status signals.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ple_pkg::CMD_W-1:0]           command,
	input  logic signed [ple_pkg::DATA_W-1:0]   data_value,
	input  logic [ple_pkg::SLOT_W-1:0]          slot_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ple_pkg::STATUS_W-1:0]        status,
	output logic signed [ple_pkg::DATA_W-1:0]   item_value,
	output logic                                item_valid,
	output logic [ple_pkg::LEN_W-1:0]           list_length,
	output logic                                last_result
);

	ple_pkg::dp_op_t  op;
	ple_pkg::dp_sts_t sts;

	// controller
	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.sts      (sts),
		.op       (op)
	);

	// datapath
	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.sts         (sts),
		.command     (command),
		.data_value  (data_value),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.item_value  (item_value),
		.item_valid  (item_valid),
		.list_length (list_length),
		.last_result (last_result)
	);

endmodule

### rtl/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller of the positional list engine: input handshake and sequencing
// of dump results, one element per cycle while the output register is free.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ple_pkg::CMD_W-1:0] command,
	input  ple_pkg::dp_sts_t      sts,
	output ple_pkg::dp_op_t       op
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   accept;

	// take a new item only when idle and the output register can be loaded
	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	// operation issued this cycle
	always_comb begin
		op = ple_pkg::DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == ple_pkg::CMD_DUMP) begin
						op = ple_pkg::DP_DUMP_START;
					end else begin
						op = ple_pkg::DP_EXEC;
					end
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					if (sts.cnt_zero) begin
						op = ple_pkg::DP_DUMP_EMPTY;
					end else begin
						op = ple_pkg::DP_DUMP_ELEM;
					end
				end
			end
			default: op = ple_pkg::DP_NOP;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (command == ple_pkg::CMD_DUMP)) begin
						state_q <= S_DUMP;
					end
				end
				S_DUMP: begin
					if (sts.out_free && (sts.cnt_zero || sts.dump_last)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/ple_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_dp
// Datapath of the positional list engine: a row of element cells that shift
// toward a neighbour, the element count, the dump counter and the output
// register.
// ----------------------------------------------------------------------------
module ple_dp #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ple_pkg::dp_op_t                     op,
	output ple_pkg::dp_sts_t                    sts,
	input  logic [ple_pkg::CMD_W-1:0]           command,
	input  logic signed [ple_pkg::DATA_W-1:0]   data_value,
	input  logic [ple_pkg::SLOT_W-1:0]          slot_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ple_pkg::STATUS_W-1:0]        status,
	output logic signed [ple_pkg::DATA_W-1:0]   item_value,
	output logic                                item_valid,
	output logic [ple_pkg::LEN_W-1:0]           list_length,
	output logic                                last_result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ERASE,
		CELL_ROTATE
	} cell_op_t;

	logic signed [ple_pkg::DATA_W-1:0] cell_q [CAPACITY];
	logic signed [ple_pkg::DATA_W-1:0] cell_d [CAPACITY];
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_d;
	logic [CW-1:0]                     dump_idx_q;
	logic [CW-1:0]                     count_m1;
	logic [CW-1:0]                     pos;
	logic [ple_pkg::SLOT_W-1:0]        count_ext;
	logic [CW+ple_pkg::LEN_W-1:0]      len_ext;
	cell_op_t                          cell_op;
	ple_pkg::status_code_t             exec_status;
	logic                              full;
	logic                              empty;
	logic                              dump_last;

	logic                              out_valid_q;
	logic [ple_pkg::STATUS_W-1:0]      status_q;
	logic signed [ple_pkg::DATA_W-1:0] item_value_q;
	logic                              item_valid_q;
	logic [ple_pkg::LEN_W-1:0]         length_q;
	logic                              last_q;

	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign count_m1  = count_q - 1'b1;
	assign count_ext = {{(ple_pkg::SLOT_W-CW){1'b0}}, count_q};
	assign dump_last = (dump_idx_q == count_m1);

	// command decode: shift kind, position, status and new count
	always_comb begin
		cell_op     = CELL_HOLD;
		pos         = '0;
		exec_status = ple_pkg::ST_DONE;
		count_d     = count_q;
		if (op == ple_pkg::DP_EXEC) begin
			unique case (command) inside
				ple_pkg::CMD_PUSH_FRONT, ple_pkg::CMD_PUSH_BACK, ple_pkg::CMD_INSERT: begin
					if (full) begin
						exec_status = ple_pkg::ST_FULL;
					end else begin
						cell_op = CELL_INSERT;
						count_d = count_q + 1'b1;
						if (command == ple_pkg::CMD_PUSH_FRONT) begin
							pos = '0;
						end else if (command == ple_pkg::CMD_PUSH_BACK) begin
							pos = count_q;
						end else if (slot_index > count_ext) begin
							pos         = count_q;
							exec_status = ple_pkg::ST_PAST_END;
						end else begin
							pos = slot_index[CW-1:0];
						end
					end
				end
				ple_pkg::CMD_ERASE: begin
					if (empty) begin
						exec_status = ple_pkg::ST_EMPTY;
					end else begin
						cell_op = CELL_ERASE;
						count_d = count_m1;
						if (slot_index >= count_ext) begin
							pos         = count_m1;
							exec_status = ple_pkg::ST_PAST_END;
						end else begin
							pos = slot_index[CW-1:0];
						end
					end
				end
				default: cell_op = CELL_HOLD;
			endcase
		end else if (op == ple_pkg::DP_DUMP_ELEM) begin
			cell_op = CELL_ROTATE;
		end
	end

	// per-cell next value from the neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic signed [ple_pkg::DATA_W-1:0] prev_v;
		logic signed [ple_pkg::DATA_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = data_value;
		end else begin : g_mid
			assign prev_v = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_v = cell_q[i];
		end else begin : g_body
			assign next_v = cell_q[i+1];
		end

		always_comb begin
			cell_d[i] = cell_q[i];
			case (cell_op)
				CELL_INSERT: begin
					if (IDX == pos) begin
						cell_d[i] = data_value;
					end else if (IDX > pos) begin
						cell_d[i] = prev_v;
					end
				end
				CELL_ERASE: begin
					if (IDX >= pos) begin
						cell_d[i] = next_v;
					end
				end
				CELL_ROTATE: begin
					if (IDX == count_m1) begin
						cell_d[i] = cell_q[0];
					end else if (IDX < count_m1) begin
						cell_d[i] = next_v;
					end
				end
				default: cell_d[i] = cell_q[i];
			endcase
		end
	end

	// element cells, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	// element count and dump counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dump_idx_q <= '0;
		end else begin
			count_q <= count_d;
			if (op == ple_pkg::DP_DUMP_START) begin
				dump_idx_q <= '0;
			end else if (op == ple_pkg::DP_DUMP_ELEM) begin
				dump_idx_q <= dump_idx_q + 1'b1;
			end
		end
	end

	assign len_ext = {{ple_pkg::LEN_W{1'b0}}, count_d};

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((op == ple_pkg::DP_EXEC) || (op == ple_pkg::DP_DUMP_ELEM) ||
				(op == ple_pkg::DP_DUMP_EMPTY)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		case (op)
			ple_pkg::DP_EXEC: begin
				status_q     <= exec_status;
				item_value_q <= '0;
				item_valid_q <= 1'b0;
				length_q     <= len_ext[ple_pkg::LEN_W-1:0];
				last_q       <= 1'b1;
			end
			ple_pkg::DP_DUMP_ELEM: begin
				status_q     <= ple_pkg::ST_DONE;
				item_value_q <= cell_q[0];
				item_valid_q <= 1'b1;
				length_q     <= len_ext[ple_pkg::LEN_W-1:0];
				last_q       <= dump_last;
			end
			ple_pkg::DP_DUMP_EMPTY: begin
				status_q     <= ple_pkg::ST_DONE;
				item_value_q <= '0;
				item_valid_q <= 1'b0;
				length_q     <= len_ext[ple_pkg::LEN_W-1:0];
				last_q       <= 1'b1;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.cnt_zero  = empty;
	assign sts.dump_last = dump_last;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item_value  = item_value_q;
	assign item_valid  = item_valid_q;
	assign list_length = length_q;
	assign last_result = last_q;

`ifndef NO_ASSERTIONS
	// count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count beyond capacity");

	// a command changes the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(op == ple_pkg::DP_EXEC) |=> ((count_q == $past(count_q)) ||
			(count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q))))
		else $error("element count jumped");

	// an element is only dumped from a non-empty list
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(op == ple_pkg::DP_DUMP_ELEM) |-> !empty)
		else $error("dump of an element from an empty list");

	// the output register is only loaded when free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		((op == ple_pkg::DP_EXEC) || (op == ple_pkg::DP_DUMP_ELEM) ||
			(op == ple_pkg::DP_DUMP_EMPTY)) |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");
`endif

endmodule
